// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/core/rrd_pkg.sv
// Package: types, constants and CRC helper for the response deframer.
`timescale 1ns / 1ps
package rrd_pkg;
    localparam int MAX_FRAME_DEF = 262;

    localparam logic [3:0] CLS_TAG       = 4'd0;
    localparam logic [3:0] CLS_KEEPALIVE = 4'd1;
    localparam logic [3:0] CLS_THROTTLE  = 4'd2;
    localparam logic [3:0] CLS_TEMP      = 4'd3;
    localparam logic [3:0] CLS_UNKNOWN   = 4'd4;
    localparam logic [3:0] CLS_CRC_ERR   = 4'd5;
    localparam logic [3:0] CLS_BAD_OP    = 4'd6;
    localparam logic [3:0] CLS_TIMEOUT   = 4'd7;
    localparam logic [3:0] CLS_STARTUP   = 4'd8;
    localparam logic [3:0] CLS_OVERSIZE  = 4'd9;

    localparam logic [2:0] REG_HEADER  = 3'd0;
    localparam logic [2:0] REG_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_TAG_OP  = 3'd2;
    localparam logic [2:0] REG_START   = 3'd3;
    localparam logic [2:0] REG_MAXLEN  = 3'd4;

    localparam logic [15:0] STAT_KEEPALIVE = 16'h0400;
    localparam logic [15:0] STAT_THROTTLE  = 16'h0504;
    localparam logic [7:0]  LEN_UNKNOWN    = 8'h08;
    localparam logic [7:0]  LEN_TEMP       = 8'h0a;

    typedef struct packed {
        logic [3:0]  frame_class;
        logic [7:0]  opcode_seen;
        logic [7:0]  length_seen;
        logic [15:0] status_word;
        logic [7:0]  rssi_dbm;
        logic [23:0] frequency_khz;
        logic [31:0] timestamp_ms;
        logic [13:0] tag_data_bytes;
        logic [7:0]  epc_bytes;
    } t_result;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] timeout_marker;
        logic [7:0] tag_read_opcode;
        logic [7:0] startup_opcode;
        logic [8:0] max_frame_bytes;
    } t_cfg;

    function automatic logic [15:0] crc_nib(input logic [15:0] c, input logic [3:0] n);
        logic [15:0] t;
        logic [3:0]  top;
        top = c[15:12];
        t = 16'h0000;
        for (int i = 0; i < 4; i++) begin
            if (top[i]) t = t ^ (16'h1021 << i);
        end
        return {c[11:0], n} ^ t;
    endfunction
endpackage

// File: rtl/core/rrd_front.sv
// Front end: frame tracking, CRC, field capture and classification.
`timescale 1ns / 1ps
module rrd_front #(
    parameter int MAX_FRAME = rrd_pkg::MAX_FRAME_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  rrd_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output rrd_pkg::t_result o_res
);
    import rrd_pkg::*;

    logic        r_in_frame;
    logic [8:0]  r_off;
    logic [15:0] r_crc;
    logic [7:0]  r_len, r_op, r_rssi, r_crch;
    logic [15:0] r_stat, r_tag, r_epc;
    logic [23:0] r_freq;
    logic [31:0] r_time;

    logic [9:0]  body_end;
    logic [9:0]  tot;
    logic [13:0] tag_b;
    logic [14:0] epc_at;
    logic [15:0] crc_nx;
    logic [12:0] q;
    logic [7:0]  epc_e;
    logic [3:0]  cls;

    assign body_end = {2'b00, (r_off == 9'd1) ? i_byte : r_len} + 10'd4;
    assign tot      = {2'b00, i_byte} + 10'd7;
    assign tag_b    = 14'((17'(r_tag) + 17'd7) >> 3);
    assign epc_at   = {1'b0, tag_b} + 15'd27;
    assign crc_nx   = crc_nib(crc_nib(r_crc, i_byte[7:4]), i_byte[3:0]);
    assign q        = r_epc[15:3];
    assign epc_e    = (q > 13'd259) ? 8'd255 : (q > 13'd4) ? 8'(q - 13'd4) : 8'd0;

    always_comb begin
        if (r_crch != r_crc[15:8] || i_byte != r_crc[7:0]) cls = CLS_CRC_ERR;
        else if (r_op == i_cfg.startup_opcode) cls = CLS_STARTUP;
        else if (r_op != i_cfg.tag_read_opcode) cls = CLS_BAD_OP;
        else if (r_len == 8'd0)
            cls = (r_stat == STAT_KEEPALIVE) ? CLS_KEEPALIVE :
                  (r_stat == STAT_THROTTLE) ? CLS_THROTTLE : CLS_UNKNOWN;
        else if (r_len == LEN_UNKNOWN) cls = CLS_UNKNOWN;
        else if (r_len == LEN_TEMP) cls = CLS_TEMP;
        else cls = CLS_TAG;
    end

    always_ff @(posedge i_clk) begin
        o_res_valid <= 1'b0;
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_off <= '0;
            r_crc <= 16'hFFFF;
            {r_len, r_op, r_rssi, r_crch, r_stat, r_tag, r_epc, r_freq, r_time} <= '0;
        end else if (i_valid) begin
            if (!r_in_frame) begin
                if (i_byte == i_cfg.header_byte) begin
                    r_in_frame <= 1'b1;
                    r_off <= 9'd1;
                    r_crc <= 16'hFFFF;
                    {r_len, r_op, r_rssi, r_crch, r_stat, r_tag, r_epc, r_freq, r_time} <= '0;
                end else if (i_byte == i_cfg.timeout_marker) begin
                    {r_len, r_op, r_rssi, r_crch, r_stat, r_tag, r_epc, r_freq, r_time} <= '0;
                    o_res_valid <= 1'b1;
                    o_res <= '{CLS_TIMEOUT, 8'd0, 8'd0, 16'd0, 8'd0, 24'd0, 32'd0,
                               14'd0, 8'd0};
                end
            end else if (r_off == 9'd1 && (tot > {1'b0, i_cfg.max_frame_bytes} ||
                         tot > 10'(MAX_FRAME))) begin
                r_len <= i_byte;
                r_in_frame <= 1'b0;
                r_off <= '0;
                o_res_valid <= 1'b1;
                o_res <= '{CLS_OVERSIZE, 8'd0, i_byte, 16'd0, 8'd0, 24'd0, 32'd0,
                           14'd0, 8'd0};
            end else if ({1'b0, r_off} <= body_end) begin
                r_crc <= crc_nx;
                r_off <= r_off + 9'd1;
                if (r_off == 9'd1) r_len <= i_byte;
                if (r_off == 9'd2) r_op <= i_byte;
                if (r_off == 9'd3) r_stat[15:8] <= i_byte;
                if (r_off == 9'd4) r_stat[7:0] <= i_byte;
                if (r_off == 9'd12) r_rssi <= i_byte;
                if (r_off >= 9'd14 && r_off <= 9'd16) r_freq <= {r_freq[15:0], i_byte};
                if (r_off >= 9'd17 && r_off <= 9'd20) r_time <= {r_time[23:0], i_byte};
                if (r_off == 9'd24 || r_off == 9'd25) r_tag <= {r_tag[7:0], i_byte};
                if (r_off >= 9'd27 && ({6'd0, r_off} == epc_at ||
                    {6'd0, r_off} == epc_at + 15'd1))
                    r_epc <= {r_epc[7:0], i_byte};
            end else if ({1'b0, r_off} == body_end + 10'd1) begin
                r_crch <= i_byte;
                r_off <= r_off + 9'd1;
            end else begin
                r_in_frame <= 1'b0;
                r_off <= '0;
                r_crc <= 16'hFFFF;
                o_res_valid <= 1'b1;
                o_res <= '{cls, r_op, r_len, r_stat, r_rssi, r_freq, r_time, tag_b, epc_e};
            end
        end
    end
endmodule

// File: rtl/core/rrd_queue.sv
// Result queue between the front end and the output port.
`timescale 1ns / 1ps
module rrd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  rrd_pkg::t_result i_data,
    output logic [1:0]       o_count,
    output logic             o_valid,
    output rrd_pkg::t_result o_data,
    input  logic             i_rd
);
    import rrd_pkg::*;
    t_result    r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       rd;

    assign rd      = i_rd && (r_cnt != 3'd0);
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rp];
    assign o_count = (r_cnt > 3'd2) ? 2'd3 : r_cnt[1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b00, i_wr} - {2'b00, rd};
        end
    end
endmodule

// File: rtl/core/reader_response_deframer.sv
// Top level of the reader response deframer.
//   channel  | direction | handshake
//   s_axis   | in        | rx byte words
//   m_axis   | out       | frame results
//   apb      | in        | configuration registers
// One byte is taken per cycle while s_axis_tready is high; the front end keeps up.
// A result is registered by the front end and then offered through a 4-entry queue.
// Input stalls only when the queue holds 2 or more results (one may be in flight).
// Reset is synchronous and active low; registers return to their listed defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module reader_response_deframer #(
    parameter int MAX_FRAME = rrd_pkg::MAX_FRAME_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // rx_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // frame_class, opcode_seen, length_seen, status_word, rssi_dbm,
    // frequency_khz, timestamp_ms, tag_data_bytes, epc_bytes, zero pad
    output logic [127:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import rrd_pkg::*;

    t_cfg       r_cfg;
    logic       f_valid;
    t_result    f_res, q_res;
    logic [1:0] q_cnt;
    logic       q_valid;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{8'hFF, 8'h00, 8'h22, 8'h00, 9'd255};
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_HEADER:  r_cfg.header_byte <= pwdata[7:0];
                REG_TIMEOUT: r_cfg.timeout_marker <= pwdata[7:0];
                REG_TAG_OP:  r_cfg.tag_read_opcode <= pwdata[7:0];
                REG_START:   r_cfg.startup_opcode <= pwdata[7:0];
                REG_MAXLEN:  r_cfg.max_frame_bytes <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_HEADER:  prdata = {24'd0, r_cfg.header_byte};
            REG_TIMEOUT: prdata = {24'd0, r_cfg.timeout_marker};
            REG_TAG_OP:  prdata = {24'd0, r_cfg.tag_read_opcode};
            REG_START:   prdata = {24'd0, r_cfg.startup_opcode};
            REG_MAXLEN:  prdata = {23'd0, r_cfg.max_frame_bytes};
            default:     prdata = 32'd0;
        endcase
    end

    assign s_axis_tready = (q_cnt < 2'd2);

    rrd_front #(.MAX_FRAME(MAX_FRAME)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid && s_axis_tready),
        .i_byte(s_axis_tdata),
        .i_cfg(r_cfg),
        .o_res_valid(f_valid),
        .o_res(f_res)
    );

    rrd_queue u_queue (
        .i_clk, .i_rst_n,
        .i_wr(f_valid), .i_data(f_res),
        .o_count(q_cnt), .o_valid(q_valid), .o_data(q_res),
        .i_rd(m_axis_tready)
    );

    assign m_axis_tvalid = q_valid;
    assign m_axis_tdata = {6'd0, q_res.epc_bytes, q_res.tag_data_bytes,
                           q_res.timestamp_ms, q_res.frequency_khz, q_res.rssi_dbm,
                           q_res.status_word, q_res.length_seen, q_res.opcode_seen,
                           q_res.frame_class};

    `ASSERT_IMPL(a_class_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[3:0] <= CLS_OVERSIZE)
    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_IMPL(a_no_full_accept, i_clk, i_rst_n, q_cnt == 2'd3, !s_axis_tready)
endmodule

// File: dv/rrd_checker.sv
// Checker for the response deframer: predicts frame results and compares them.
`timescale 1ns / 1ps
module rrd_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [7:0]   i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [127:0] i_m_tdata,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [4:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    input  logic         i_pready,
    output int           o_errors,
    output int           o_pending
);
    import rrd_pkg::*;

    typedef struct {
        logic [3:0]  cls;
        logic [7:0]  opcode;
        logic [7:0]  length;
        logic [15:0] status;
        logic [7:0]  rssi;
        logic [23:0] freq;
        logic [31:0] stamp;
        logic [13:0] tag_bytes;
        logic [7:0]  epc;
    } frame_rec_t;

    frame_rec_t expected_frames[$];

    logic [7:0]  cfg_hdr, cfg_tmo, cfg_tag, cfg_start;
    logic [8:0]  cfg_max;
    int          offset;
    bit          framing;
    logic [15:0] crc;
    logic [7:0]  len_l, op_l, crc_hi_l, rssi_l;
    logic [15:0] stat_l, tagbits_l, epcbits_l;
    logic [23:0] freq_l;
    logic [31:0] time_l;

    assign o_pending = expected_frames.size();

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [3:0] n);
        logic [15:0] t;
        t = {12'h000, c[15:12]};
        return {c[11:0], n} ^ (t << 12) ^ (t << 5) ^ t;
    endfunction

    function automatic logic [13:0] tag_len();
        return 14'((17'(tagbits_l) + 17'd7) >> 3);
    endfunction

    task automatic clear_fields();
        len_l = 0; op_l = 0; stat_l = 0; rssi_l = 0; freq_l = 0; time_l = 0;
        tagbits_l = 0; epcbits_l = 0; crc_hi_l = 0;
    endtask

    task automatic push_frame(input logic [3:0] cls, input bit full);
        frame_rec_t r;
        int q;
        q = epcbits_l >> 3;
        r.cls = cls;
        r.length = len_l;
        r.opcode = full ? op_l : 8'h00;
        r.status = full ? stat_l : 16'h0000;
        r.rssi = full ? rssi_l : 8'h00;
        r.freq = full ? freq_l : 24'h0;
        r.stamp = full ? time_l : 32'h0;
        r.tag_bytes = full ? tag_len() : 14'h0;
        r.epc = !full ? 8'h00 : (q <= 4) ? 8'h00 : (q - 4 > 255) ? 8'hFF : 8'(q - 4);
        expected_frames.push_back(r);
    endtask

    task automatic take_byte(input logic [7:0] b);
        int body_end;
        int epc_at;
        logic [3:0] cls;
        if (!framing) begin
            if (b == cfg_hdr) begin
                framing = 1; offset = 1; crc = 16'hFFFF;
                clear_fields();
            end else if (b == cfg_tmo) begin
                clear_fields();
                push_frame(CLS_TIMEOUT, 0);
            end
            return;
        end
        if (offset == 1) begin
            len_l = b;
            if (int'(b) + 7 > int'(cfg_max) || int'(b) + 7 > MAX_FRAME_DEF) begin
                push_frame(CLS_OVERSIZE, 0);
                framing = 0; offset = 0;
                return;
            end
        end
        body_end = int'(len_l) + 4;
        if (offset <= body_end) begin
            crc = crc_step(crc, b[7:4]);
            crc = crc_step(crc, b[3:0]);
            case (offset)
                2: op_l = b;
                3: stat_l[15:8] = b;
                4: stat_l[7:0] = b;
                12: rssi_l = b;
                14, 15, 16: freq_l = {freq_l[15:0], b};
                17, 18, 19, 20: time_l = {time_l[23:0], b};
                24, 25: tagbits_l = {tagbits_l[7:0], b};
                default: ;
            endcase
            if (offset >= 27) begin
                epc_at = 27 + int'(tag_len());
                if (offset == epc_at || offset == epc_at + 1)
                    epcbits_l = {epcbits_l[7:0], b};
            end
            offset++;
            return;
        end
        if (offset == body_end + 1) begin
            crc_hi_l = b;
            offset++;
            return;
        end
        if (crc_hi_l != crc[15:8] || b != crc[7:0]) cls = CLS_CRC_ERR;
        else if (op_l == cfg_start) cls = CLS_STARTUP;
        else if (op_l != cfg_tag) cls = CLS_BAD_OP;
        else if (len_l == 8'h00)
            cls = (stat_l == STAT_KEEPALIVE) ? CLS_KEEPALIVE :
                  (stat_l == STAT_THROTTLE) ? CLS_THROTTLE : CLS_UNKNOWN;
        else if (len_l == LEN_UNKNOWN) cls = CLS_UNKNOWN;
        else if (len_l == LEN_TEMP) cls = CLS_TEMP;
        else cls = CLS_TAG;
        push_frame(cls, 1);
        framing = 0; offset = 0; crc = 16'hFFFF;
    endtask

    task automatic field_check(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            o_errors++;
        end
    endtask

    task automatic compare_word(input logic [127:0] d);
        frame_rec_t e;
        if (expected_frames.size() == 0) begin
            $display("%0t: unexpected result word: expected none, actual %h", $time, d);
            o_errors++;
            return;
        end
        e = expected_frames.pop_front();
        field_check("frame_class", e.cls, d[3:0]);
        field_check("opcode_seen", e.opcode, d[11:4]);
        field_check("length_seen", e.length, d[19:12]);
        field_check("status_word", e.status, d[35:20]);
        field_check("rssi_dbm", e.rssi, d[43:36]);
        field_check("frequency_khz", e.freq, d[67:44]);
        field_check("timestamp_ms", e.stamp, d[99:68]);
        field_check("tag_data_bytes", e.tag_bytes, d[113:100]);
        field_check("epc_bytes", e.epc, d[121:114]);
        field_check("pad", 32'h0, {26'h0, d[127:122]});
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_hdr <= 8'hFF; cfg_tmo <= 8'h00; cfg_tag <= 8'h22; cfg_start <= 8'h00;
            cfg_max <= 9'd255;
            framing = 0; offset = 0; crc = 16'hFFFF;
            clear_fields();
        end else begin
            if (i_m_tvalid && i_m_tready) compare_word(i_m_tdata);
            if (i_s_tvalid && i_s_tready) take_byte(i_s_tdata);
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_HEADER:  cfg_hdr <= i_pwdata[7:0];
                    REG_TIMEOUT: cfg_tmo <= i_pwdata[7:0];
                    REG_TAG_OP:  cfg_tag <= i_pwdata[7:0];
                    REG_START:   cfg_start <= i_pwdata[7:0];
                    REG_MAXLEN:  cfg_max <= i_pwdata[8:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: dv/tb.sv
// Testbench top: drives response bytes and register settings into the deframer.
`timescale 1ns / 1ps
module tb;
    import rrd_pkg::*;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [127:0] m_axis_tdata;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [4:0]   paddr = 0;
    logic [31:0]  pwdata = 0;
    logic [31:0]  prdata;
    logic         pready;
    int           errors, pending;

    logic [7:0]   cur_hdr = 8'hFF, cur_tmo = 8'h00, cur_tag = 8'h22, cur_start = 8'h00;
    int           cur_max = 255;
    bit           no_idle = 0;
    int           phase_bytes;

    always #10 i_clk = ~i_clk;

    reader_response_deframer u_top (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    rrd_checker u_chk (
        .i_clk, .i_rst_n,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready), .i_s_tdata(s_axis_tdata),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready), .i_m_tdata(m_axis_tdata),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready), .o_errors(errors), .o_pending(pending)
    );

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [15:0] crc_add(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic [15:0] t;
        r = c;
        for (int i = 0; i < 2; i++) begin
            t = {12'h000, r[15:12]};
            r = {r[11:0], (i == 0) ? b[7:4] : b[3:0]} ^ (t << 12) ^ (t << 5) ^ t;
        end
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        phase_bytes++;
    endtask

    // Stray byte outside a frame; never the header so frame boundaries stay known.
    task automatic send_stray();
        logic [7:0] b;
        do b = 8'($urandom); while (b == cur_hdr);
        send_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] op,
                              input logic [15:0] st, input bit corrupt);
        logic [7:0]  fb[$];
        logic [15:0] crc;
        int          pos;
        fb.push_back(cur_hdr);
        fb.push_back(len);
        if (int'(len) + 7 > cur_max || int'(len) + 7 > MAX_FRAME_DEF) begin
            send_byte(fb[0]);
            send_byte(fb[1]);
            return;
        end
        fb.push_back(op);
        fb.push_back(st[15:8]);
        fb.push_back(st[7:0]);
        for (int i = 0; i < len; i++) fb.push_back(8'($urandom));
        // Keep the embedded tag length short so the EPC field usually lands inside.
        if (len >= 21 && $urandom_range(0, 3) != 0) begin
            fb[24] = 8'h00;
            fb[25] = 8'($urandom_range(0, 90));
        end
        crc = 16'hFFFF;
        for (int i = 1; i < fb.size(); i++) crc = crc_add(crc, fb[i]);
        fb.push_back(crc[15:8]);
        fb.push_back(crc[7:0]);
        if (corrupt) begin
            pos = $urandom_range(1, fb.size() - 1);
            fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        foreach (fb[i]) send_byte(fb[i]);
    endtask

    task automatic random_frame();
        logic [7:0]  len, op;
        logic [15:0] st;
        case ($urandom_range(0, 9))
            0: len = 8'h00;
            1: len = LEN_UNKNOWN;
            2: len = LEN_TEMP;
            3: len = 8'($urandom_range(0, 255));
            default: len = 8'($urandom_range(11, 40));
        endcase
        case ($urandom_range(0, 7))
            0: op = cur_start;
            1: op = 8'($urandom);
            default: op = cur_tag;
        endcase
        case ($urandom_range(0, 3))
            0: st = STAT_KEEPALIVE;
            1: st = STAT_THROTTLE;
            default: st = 16'($urandom);
        endcase
        send_frame(len, op, st, $urandom_range(0, 7) == 0);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic configure(input logic [7:0] h, input logic [7:0] t, input logic [7:0] g,
                             input logic [7:0] s, input int mx);
        s_axis_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        reg_write(REG_HEADER, {24'd0, h});
        reg_write(REG_TIMEOUT, {24'd0, t});
        reg_write(REG_TAG_OP, {24'd0, g});
        reg_write(REG_START, {24'd0, s});
        reg_write(REG_MAXLEN, 32'(mx));
        cur_hdr = h; cur_tmo = t; cur_tag = g; cur_start = s; cur_max = mx;
    endtask

    task automatic random_phase(input int nbytes);
        phase_bytes = 0;
        while (phase_bytes < nbytes) begin
            if ($urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 1) == 0 && cur_tmo != cur_hdr) send_byte(cur_tmo);
                else send_stray();
            end else begin
                random_frame();
            end
        end
    endtask

    // Result side: random stalls per word, with stretches of none.
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_axis_tready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: every class and the framing corner cases at reset settings.
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_frame(8'h00, 8'h22, STAT_KEEPALIVE, 0);
        send_frame(8'h00, 8'h22, STAT_THROTTLE, 0);
        send_frame(8'h00, 8'h22, 16'hFFFF, 0);
        send_frame(LEN_UNKNOWN, 8'h22, 16'h0000, 0);
        send_frame(LEN_TEMP, 8'h22, 16'h1234, 0);
        send_frame(8'd40, 8'h22, 16'h8000, 0);
        send_frame(8'd30, 8'h22, 16'h0001, 1);
        send_frame(8'd12, 8'h7F, 16'h0000, 0);
        send_frame(8'd3, 8'h00, 16'h0000, 0);
        send_frame(8'd255, 8'h22, 16'h0000, 0);
        send_frame(8'd248, 8'h22, 16'h0000, 0);
        send_frame(8'd249, 8'h22, 16'h0000, 0);
        send_byte(8'h00);

        random_phase(85);
        configure(8'h00, 8'hFF, 8'hFF, 8'h00, 7);
        send_frame(8'h00, 8'hFF, STAT_KEEPALIVE, 0);
        send_frame(8'h01, 8'hFF, STAT_KEEPALIVE, 0);
        random_phase(85);
        configure(8'hA5, 8'hA5, 8'h22, 8'h01, 262);
        send_frame(8'd255, 8'h22, 16'hABCD, 0);
        random_phase(85);
        configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  $urandom_range(7, 262));
        random_phase(85);
        no_idle = 1;
        configure(8'hFF, 8'h00, 8'h22, 8'h00, 255);
        random_phase(85);
        no_idle = 0;

        s_axis_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
